// ----- rtl/hds_pkg.sv -----
package hds_pkg;

  localparam int TEMP_W         = 16;
  localparam int COEF_W         = 16;
  localparam int TEMP_FRAC_BITS = 15;
  localparam int W_IN_W         = COEF_W + 1;
  localparam int W_OUT_W        = COEF_W + 2;
  localparam int PROD_C_W       = W_IN_W + TEMP_W;
  localparam int PROD_N_W       = W_OUT_W + TEMP_W;
  localparam int PAIR_W         = PROD_N_W + 1;
  localparam int ACC_W          = 37;
  localparam int SUM_W          = 21;
  localparam int Q_W            = TEMP_W;
  localparam int NB             = 4;
  localparam int CNT_W          = 3;

  localparam logic [COEF_W-1:0] OUTER_COEF_RST = 16'd1638;
  localparam logic [W_IN_W-1:0] W_IN_FULL      = 17'h10000;
  localparam logic [Q_W:0]      TEMP_ONE       = (Q_W + 1)'(1) << TEMP_FRAC_BITS;

  typedef struct packed {
    logic [SUM_W-1:0]  rem;
    logic [Q_W-1:0]    low;
    logic [Q_W-1:0]    quo;
    logic [SUM_W-1:0]  den;
    logic              pass;
    logic [TEMP_W-1:0] ct;
  } div_word_t;

endpackage

// ----- rtl/heat_diffusion_stencil_cell.sv -----
// Five-point heat diffusion cell update, fully pipelined.
// Each word passes the stage 1, stage 2 and stage 3 registers, the divider stages and the output register.
// Throughput: one word per cycle; busy is never raised and the receiver cannot stall.
// The quotient comes from a 16-stage restoring divider, one quotient bit per stage.
// Reset (rst_n low, synchronous) empties the pipeline and loads outer_coef with 1638.
module heat_diffusion_stencil_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [hds_pkg::TEMP_W-1:0] in_centre_temp,
  input  logic                       in_centre_insulator,
  input  logic                       in_centre_fixed,
  input  logic [hds_pkg::TEMP_W-1:0] in_up_temp,
  input  logic                       in_up_insulator,
  input  logic [hds_pkg::TEMP_W-1:0] in_down_temp,
  input  logic                       in_down_insulator,
  input  logic [hds_pkg::TEMP_W-1:0] in_left_temp,
  input  logic                       in_left_insulator,
  input  logic [hds_pkg::TEMP_W-1:0] in_right_temp,
  input  logic                       in_right_insulator,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [hds_pkg::COEF_W-1:0] cfg_data,
  output logic                       out_valid,
  output logic [hds_pkg::TEMP_W-1:0] out_new_temp
);
  import hds_pkg::*;

  logic [W_IN_W-1:0]  w_in_r;
  logic [W_OUT_W-1:0] w_out_r;

  logic [TEMP_W-1:0]  nb_temp [NB];
  logic [NB-1:0]      nb_ins;

  logic                s1_valid_r;
  logic                s1_pass_r;
  logic [TEMP_W-1:0]   s1_ct_r;
  logic [PROD_C_W-1:0] s1_pc_r;
  logic [PROD_N_W-1:0] s1_pn_r [NB];
  logic [CNT_W-1:0]    s1_cnt_r;
  logic [CNT_W-1:0]    cnt_nxt;

  logic                s2_valid_r;
  logic                s2_pass_r;
  logic [TEMP_W-1:0]   s2_ct_r;
  logic [PAIR_W-1:0]   s2_a_r;
  logic [PAIR_W-1:0]   s2_b_r;
  logic [PROD_N_W-1:0] s2_n3_r;
  logic [SUM_W-1:0]    s2_sum_r;
  logic [SUM_W-1:0]    nsum_nxt;

  logic                s3_valid_r;
  div_word_t           s3_word_r;
  logic [ACC_W-1:0]    acc_nxt;

  logic                dv_valid_r [Q_W+1];
  div_word_t           dv_word_r  [Q_W+1];
  div_word_t           dv_word_nxt [1:Q_W];

  logic                out_valid_r;
  logic [TEMP_W-1:0]   out_temp_r;
  logic [TEMP_W-1:0]   out_temp_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_in_r  <= W_IN_FULL - W_IN_W'(OUTER_COEF_RST);
      w_out_r <= {OUTER_COEF_RST, 2'b00};
    end else if (cfg_valid && cfg_ready) begin
      w_in_r  <= W_IN_FULL - W_IN_W'(cfg_data);
      w_out_r <= {cfg_data, 2'b00};
    end
  end

  assign nb_temp[0] = in_up_temp;
  assign nb_temp[1] = in_down_temp;
  assign nb_temp[2] = in_left_temp;
  assign nb_temp[3] = in_right_temp;
  assign nb_ins     = {in_right_insulator, in_left_insulator, in_down_insulator, in_up_insulator};

  // stage 1: weighted products
  always_comb begin
    cnt_nxt = '0;
    for (int k = 0; k < NB; k++) begin
      cnt_nxt = cnt_nxt + CNT_W'(!nb_ins[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    s1_pass_r <= in_centre_insulator || in_centre_fixed;
    s1_ct_r   <= in_centre_temp;
    s1_pc_r   <= PROD_C_W'(w_in_r) * PROD_C_W'(in_centre_temp);
    s1_cnt_r  <= cnt_nxt;
    for (int k = 0; k < NB; k++) begin
      s1_pn_r[k] <= nb_ins[k] ? '0 : PROD_N_W'(w_out_r) * PROD_N_W'(nb_temp[k]);
    end
  end

  // stage 2: pair sums and weight sum
  always_comb begin
    case (s1_cnt_r)
      3'd0:    nsum_nxt = '0;
      3'd1:    nsum_nxt = SUM_W'(w_out_r);
      3'd2:    nsum_nxt = SUM_W'({w_out_r, 1'b0});
      3'd3:    nsum_nxt = SUM_W'({w_out_r, 1'b0}) + SUM_W'(w_out_r);
      3'd4:    nsum_nxt = SUM_W'({w_out_r, 2'b00});
      default: nsum_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
    end else begin
      s2_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s2_pass_r <= s1_pass_r;
    s2_ct_r   <= s1_ct_r;
    s2_a_r    <= PAIR_W'(s1_pc_r) + PAIR_W'(s1_pn_r[0]);
    s2_b_r    <= PAIR_W'(s1_pn_r[1]) + PAIR_W'(s1_pn_r[2]);
    s2_n3_r   <= s1_pn_r[3];
    s2_sum_r  <= SUM_W'(w_in_r) + nsum_nxt;
  end

  // stage 3: full accumulator, split for the divider
  assign acc_nxt = ACC_W'(s2_a_r) + ACC_W'(s2_b_r) + ACC_W'(s2_n3_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_valid_r <= 1'b0;
    end else begin
      s3_valid_r <= s2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_word_r.rem  <= acc_nxt[ACC_W-1:Q_W];
    s3_word_r.low  <= acc_nxt[Q_W-1:0];
    s3_word_r.quo  <= '0;
    s3_word_r.den  <= s2_sum_r;
    s3_word_r.pass <= s2_pass_r;
    s3_word_r.ct   <= s2_ct_r;
  end

  assign dv_valid_r[0]  = s3_valid_r;
  assign dv_word_r[0]   = s3_word_r;

  // divider: one restoring step per stage
  for (genvar g = 1; g <= Q_W; g++) begin : g_div
    logic [SUM_W:0] trial;
    logic           ge;

    always_comb begin
      trial = {dv_word_r[g-1].rem, dv_word_r[g-1].low[Q_W-1]};
      ge    = trial >= {1'b0, dv_word_r[g-1].den};
      dv_word_nxt[g]      = dv_word_r[g-1];
      dv_word_nxt[g].rem  = ge ? SUM_W'(trial - {1'b0, dv_word_r[g-1].den})
                               : trial[SUM_W-1:0];
      dv_word_nxt[g].low  = {dv_word_r[g-1].low[Q_W-2:0], 1'b0};
      dv_word_nxt[g].quo  = {dv_word_r[g-1].quo[Q_W-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_valid_r[g] <= 1'b0;
      end else begin
        dv_valid_r[g] <= dv_valid_r[g-1];
      end
    end

    always_ff @(posedge clk) begin
      dv_word_r[g] <= dv_word_nxt[g];
    end
  end

  // output: clamp or pass through
  always_comb begin
    if (dv_word_r[Q_W].pass) begin
      out_temp_nxt = dv_word_r[Q_W].ct;
    end else if ({1'b0, dv_word_r[Q_W].quo} > TEMP_ONE) begin
      out_temp_nxt = TEMP_ONE[Q_W-1:0];
    end else begin
      out_temp_nxt = dv_word_r[Q_W].quo;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_valid_r[Q_W];
    end
  end

  always_ff @(posedge clk) begin
    out_temp_r <= out_temp_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_new_temp = out_temp_r;

endmodule
